// ----- rtl/json_token_lexer_top_macros.svh -----
// assertion macros for the json token lexer
// each use samples on clk and is disabled while rst_n is low
`ifndef JSON_TOKEN_LEXER_TOP_MACROS_SVH
`define JSON_TOKEN_LEXER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define JTL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define JTL_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`define JTL_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define JTL_ASSERT(lbl, cond, msg)

`define JTL_ASSERT_IMP(lbl, pre, post, msg)

`define JTL_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

// ----- rtl/jtl_pkg.sv -----
package jtl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_TEXT = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_BARE = 3'd3,
    MODE_SKIP = 3'd4
  } lex_mode_t;

  // token kinds
  localparam logic [2:0] KIND_SYMBOL = 3'd0;
  localparam logic [2:0] KIND_TEXT   = 3'd1;
  localparam logic [2:0] KIND_NULL   = 3'd2;
  localparam logic [2:0] KIND_BOOL   = 3'd3;
  localparam logic [2:0] KIND_NUMBER = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_ESCAPE = 2'd1;
  localparam logic [1:0] ERR_BARE   = 2'd2;
  localparam logic [1:0] ERR_UNTERM = 2'd3;

  // number recognizer states
  localparam logic [2:0] NUM_START    = 3'd0;
  localparam logic [2:0] NUM_SIGN     = 3'd1;
  localparam logic [2:0] NUM_INT      = 3'd2;
  localparam logic [2:0] NUM_INT_DOT  = 3'd3;
  localparam logic [2:0] NUM_INT_FRAC = 3'd4;
  localparam logic [2:0] NUM_DOT      = 3'd5;
  localparam logic [2:0] NUM_DOT_FRAC = 3'd6;
  localparam logic [2:0] NUM_DEAD     = 3'd7;

  // keyword candidate bits
  localparam int KW_NULL  = 0;
  localparam int KW_FALSE = 1;
  localparam int KW_TRUE  = 2;
  localparam int KW_NUM   = 3;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // result queue depth, power of two, at least two
  localparam int RESQ_DEPTH = 4;

  typedef struct packed {
    logic [7:0] token_char;
    logic       has_char;
    logic       starts_token;
    logic       ends_token;
    logic [2:0] kind;
    logic [1:0] error;
    logic       last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACK) ||
           (c == CH_RBRACK) || (c == CH_COMMA) || (c == CH_COLON);
  endfunction

  function automatic logic is_escape(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_B) ||
           (c == CH_F) || (c == CH_N) || (c == CH_R) || (c == CH_T);
  endfunction

  function automatic logic [2:0] num_next(input logic [2:0] s, input logic [7:0] c);
    logic [2:0] r;
    r = NUM_DEAD;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (s <= NUM_INT) r = NUM_INT;
      else if (s == NUM_INT_DOT || s == NUM_INT_FRAC) r = NUM_INT_FRAC;
      else if (s == NUM_DOT || s == NUM_DOT_FRAC) r = NUM_DOT_FRAC;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (s == NUM_START) r = NUM_SIGN;
    end else if (c == CH_DOT) begin
      if (s <= NUM_SIGN) r = NUM_DOT;
      else if (s == NUM_INT) r = NUM_INT_DOT;
    end
    return r;
  endfunction

  function automatic logic num_accept(input logic [2:0] s);
    return (s == NUM_INT) || (s == NUM_INT_DOT) || (s == NUM_INT_FRAC) ||
           (s == NUM_DOT_FRAC);
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    return (k == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  // keyword byte at a position, zero past the end
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (k == KW_NULL) begin
      unique case (pos)
        3'd0:    r = CH_N;
        3'd1:    r = CH_U;
        3'd2:    r = CH_L;
        3'd3:    r = CH_L;
        default: r = 8'h00;
      endcase
    end else if (k == KW_FALSE) begin
      unique case (pos)
        3'd0:    r = CH_F;
        3'd1:    r = CH_A;
        3'd2:    r = CH_L;
        3'd3:    r = CH_S;
        3'd4:    r = CH_E;
        default: r = 8'h00;
      endcase
    end else begin
      unique case (pos)
        3'd0:    r = CH_T;
        3'd1:    r = CH_R;
        3'd2:    r = CH_U;
        3'd3:    r = CH_E;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/jtl_lexer.sv -----
module jtl_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [7:0]        ch_i,
  input  logic              eol_i,
  output jtl_pkg::result_t  res0_o,
  output jtl_pkg::result_t  res1_o,
  output logic [1:0]        n_res_o
);

  jtl_pkg::lex_mode_t mode_r, mode_nxt;
  logic [2:0] dfa_r, dfa_nxt;
  logic [2:0] km_r, km_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       ts_r, ts_nxt;

  // state after taking ch_i as a bare byte
  logic       in_bare;
  logic [2:0] base_dfa, base_km, base_pos;
  logic [2:0] bb_dfa, bb_km, bb_pos;
  logic [2:0] bare_kind;
  logic       bare_ok;

  function automatic jtl_pkg::result_t mk_res(input logic [7:0] c, input logic has,
                                              input logic st, input logic en,
                                              input logic [2:0] kind,
                                              input logic [1:0] err);
    jtl_pkg::result_t r;
    r.token_char   = has ? c : 8'h00;
    r.has_char     = has;
    r.starts_token = st;
    r.ends_token   = en;
    r.kind         = kind;
    r.error        = err;
    r.last         = 1'b0;
    return r;
  endfunction

  always_comb begin
    in_bare  = (mode_r == jtl_pkg::MODE_BARE);
    base_dfa = in_bare ? (ts_r ? jtl_pkg::NUM_DEAD : dfa_r) : jtl_pkg::NUM_START;
    base_km  = in_bare ? (ts_r ? 3'b000 : km_r) : 3'b111;
    base_pos = in_bare ? pos_r : 3'd0;
    bb_dfa   = jtl_pkg::num_next(base_dfa, ch_i);
    bb_km    = base_km;
    for (int k = 0; k < jtl_pkg::KW_NUM; k++) begin
      if (base_pos >= jtl_pkg::kw_len(k) || jtl_pkg::kw_char(k, base_pos) != ch_i)
        bb_km[k] = 1'b0;
    end
    bb_pos   = (base_pos < 3'd7) ? base_pos + 3'd1 : base_pos;
  end

  // kind of the bare token held in state
  always_comb begin
    bare_ok = 1'b1;
    if (km_r[jtl_pkg::KW_NULL] && pos_r == 3'd4) begin
      bare_kind = jtl_pkg::KIND_NULL;
    end else if ((km_r[jtl_pkg::KW_FALSE] && pos_r == 3'd5) ||
                 (km_r[jtl_pkg::KW_TRUE] && pos_r == 3'd4)) begin
      bare_kind = jtl_pkg::KIND_BOOL;
    end else if (jtl_pkg::num_accept(dfa_r)) begin
      bare_kind = jtl_pkg::KIND_NUMBER;
    end else begin
      bare_kind = jtl_pkg::KIND_SYMBOL;
      bare_ok   = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    dfa_nxt  = dfa_r;
    km_nxt   = km_r;
    pos_nxt  = pos_r;
    ts_nxt   = ts_r;
    res0_o   = '0;
    res1_o   = '0;
    n_res_o  = 2'd0;
    unique case (mode_r)
      jtl_pkg::MODE_TEXT, jtl_pkg::MODE_ESC: begin
        if (eol_i) begin
          res0_o   = mk_res(8'h00, 1'b0, 1'b0, 1'b1, jtl_pkg::KIND_SYMBOL,
                            (mode_r == jtl_pkg::MODE_ESC) ? jtl_pkg::ERR_ESCAPE
                                                          : jtl_pkg::ERR_UNTERM);
          n_res_o  = 2'd1;
          mode_nxt = jtl_pkg::MODE_IDLE;
        end else if (mode_r == jtl_pkg::MODE_ESC) begin
          n_res_o = 2'd1;
          if (jtl_pkg::is_escape(ch_i)) begin
            res0_o   = mk_res(ch_i, 1'b1, 1'b0, 1'b0, jtl_pkg::KIND_SYMBOL,
                              jtl_pkg::ERR_NONE);
            mode_nxt = jtl_pkg::MODE_TEXT;
          end else begin
            res0_o   = mk_res(8'h00, 1'b0, 1'b0, 1'b1, jtl_pkg::KIND_SYMBOL,
                              jtl_pkg::ERR_ESCAPE);
            mode_nxt = jtl_pkg::MODE_SKIP;
          end
        end else if (ch_i == jtl_pkg::CH_QUOTE) begin
          res0_o   = mk_res(ch_i, 1'b1, 1'b0, 1'b1, jtl_pkg::KIND_TEXT, jtl_pkg::ERR_NONE);
          n_res_o  = 2'd1;
          mode_nxt = jtl_pkg::MODE_IDLE;
        end else begin
          res0_o  = mk_res(ch_i, 1'b1, 1'b0, 1'b0, jtl_pkg::KIND_SYMBOL, jtl_pkg::ERR_NONE);
          n_res_o = 2'd1;
          if (ch_i == jtl_pkg::CH_BSLASH) mode_nxt = jtl_pkg::MODE_ESC;
        end
      end
      jtl_pkg::MODE_BARE: begin
        if (eol_i || jtl_pkg::is_symbol(ch_i)) begin
          n_res_o = 2'd1;
          if (!bare_ok) begin
            res0_o   = mk_res(8'h00, 1'b0, 1'b0, 1'b1, jtl_pkg::KIND_SYMBOL,
                              jtl_pkg::ERR_BARE);
            mode_nxt = eol_i ? jtl_pkg::MODE_IDLE : jtl_pkg::MODE_SKIP;
          end else begin
            res0_o   = mk_res(8'h00, 1'b0, 1'b0, 1'b1, bare_kind, jtl_pkg::ERR_NONE);
            mode_nxt = jtl_pkg::MODE_IDLE;
            if (!eol_i) begin
              // the closing symbol is a token of its own
              res1_o  = mk_res(ch_i, 1'b1, 1'b1, 1'b1, jtl_pkg::KIND_SYMBOL,
                               jtl_pkg::ERR_NONE);
              n_res_o = 2'd2;
            end
          end
        end else if (jtl_pkg::is_space(ch_i)) begin
          ts_nxt = 1'b1;
        end else begin
          dfa_nxt = bb_dfa;
          km_nxt  = bb_km;
          pos_nxt = bb_pos;
          ts_nxt  = 1'b0;
          res0_o  = mk_res(ch_i, 1'b1, 1'b0, 1'b0, jtl_pkg::KIND_SYMBOL, jtl_pkg::ERR_NONE);
          n_res_o = 2'd1;
        end
      end
      jtl_pkg::MODE_SKIP: begin
        if (eol_i) mode_nxt = jtl_pkg::MODE_IDLE;
      end
      default: begin
        // idle, and any code without meaning
        if (eol_i) begin
          mode_nxt = jtl_pkg::MODE_IDLE;
        end else if (jtl_pkg::is_space(ch_i)) begin
          mode_nxt = mode_r;
        end else if (jtl_pkg::is_symbol(ch_i)) begin
          res0_o  = mk_res(ch_i, 1'b1, 1'b1, 1'b1, jtl_pkg::KIND_SYMBOL, jtl_pkg::ERR_NONE);
          n_res_o = 2'd1;
        end else if (ch_i == jtl_pkg::CH_QUOTE) begin
          res0_o   = mk_res(ch_i, 1'b1, 1'b1, 1'b0, jtl_pkg::KIND_SYMBOL, jtl_pkg::ERR_NONE);
          n_res_o  = 2'd1;
          mode_nxt = jtl_pkg::MODE_TEXT;
        end else begin
          res0_o   = mk_res(ch_i, 1'b1, 1'b1, 1'b0, jtl_pkg::KIND_SYMBOL, jtl_pkg::ERR_NONE);
          n_res_o  = 2'd1;
          mode_nxt = jtl_pkg::MODE_BARE;
          dfa_nxt  = bb_dfa;
          km_nxt   = bb_km;
          pos_nxt  = bb_pos;
          ts_nxt   = 1'b0;
        end
      end
    endcase
    // the recognizers are cleared whenever the next mode is not bare
    if (mode_nxt != jtl_pkg::MODE_BARE) begin
      dfa_nxt = jtl_pkg::NUM_START;
      km_nxt  = 3'b111;
      pos_nxt = 3'd0;
      ts_nxt  = 1'b0;
    end
    if (n_res_o == 2'd2) res1_o.last = 1'b1;
    else if (n_res_o == 2'd1) res0_o.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jtl_pkg::MODE_IDLE;
      dfa_r  <= jtl_pkg::NUM_START;
      km_r   <= 3'b111;
      pos_r  <= 3'd0;
      ts_r   <= 1'b0;
    end else if (step_i) begin
      mode_r <= mode_nxt;
      dfa_r  <= dfa_nxt;
      km_r   <= km_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
    end
  end

endmodule

// ----- rtl/json_token_lexer_top.sv -----
// channel  dir  handshake           payload
// in_      in   in_tvalid/tready    in_tdata = byte, in_tlast = line end
// out_     out  out_tvalid/tready   out_tdata = token char, out_tuser = marks, out_tlast
//
// one byte per cycle while the queue has room: an item waits in the input register,
// then the lexer step moves it into a four-entry result queue
// an item that makes two results (bare token closed by a symbol) takes two queue
// entries; the input side keeps going while the queue has two free entries
// reset (rst_n low, synchronous) empties both stages and puts the lexer between tokens
// a stall on out_tready fills the queue and then holds the input register
`include "json_token_lexer_top_macros.svh"

module json_token_lexer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // end_of_line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_char
  output logic [7:0] out_tuser,  // [0] has_char, [1] starts_token, [2] ends_token,
                                 // [5:3] kind, [7:6] error
  output logic       out_tlast   // last result of this input transfer
);

  localparam int Depth = jtl_pkg::RESQ_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_ch_r;
  logic       in_eol_r;
  logic       in_fire;

  // lexer step
  logic             step;
  jtl_pkg::result_t res0, res1;
  logic [1:0]       n_res;

  // result queue
  jtl_pkg::result_t resq_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             pop;
  jtl_pkg::result_t head;

  // the lexer advances only when both results of the item would fit
  assign step      = in_vld_r && (cnt_r <= CntW'(Depth - 2));
  assign in_tready = !in_vld_r || step;
  assign in_fire   = in_tvalid && in_tready;
  assign in_vld_nxt = in_fire ? 1'b1 : (step ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_ch_r  <= in_tdata;
      in_eol_r <= in_tlast;
    end
  end

  jtl_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .ch_i    (in_ch_r),
    .eol_i   (in_eol_r),
    .res0_o  (res0),
    .res1_o  (res1),
    .n_res_o (n_res)
  );

  // result queue, up to two writes and one read per cycle
  assign head       = resq_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = head.token_char;
  assign out_tuser  = {head.error, head.kind, head.ends_token, head.starts_token,
                       head.has_char};
  assign out_tlast  = head.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r - CntW'(pop);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    if (step) begin
      wr_ptr_nxt = wr_ptr_r + PtrW'(n_res);
      cnt_nxt    = cnt_r + CntW'(n_res) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (step && n_res != 2'd0) resq_r[wr_ptr_r] <= res0;
    if (step && n_res == 2'd2) resq_r[wr_ptr_r + PtrW'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `JTL_ASSERT(a_resq_no_overflow, cnt_r <= CntW'(Depth), "result queue overflow")
  `JTL_ASSERT_IMP(a_step_has_room, step, cnt_r <= CntW'(Depth - 2), "step without room")
  `JTL_ASSERT_IMP(a_err_ends_token, out_tvalid && out_tuser[7:6] != jtl_pkg::ERR_NONE,
                  out_tuser[2], "error result does not end a token")
  `JTL_ASSERT_IMP(a_nochar_zero, out_tvalid && !out_tuser[0], out_tdata == 8'h00,
                  "token char set without has_char")
  `JTL_ASSERT_NXT(a_hold_stalled_item, in_vld_r && !step,
                  in_vld_r && $stable(in_ch_r) && $stable(in_eol_r),
                  "stalled input item lost")

endmodule

// ----- tb/json_token_lexer_top_test.sv -----
`timescale 1ns / 1ps

module json_token_lexer_top_test;
  import jtl_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES = 20;   // latency allowance once nothing is expected

  typedef struct {
    logic [7:0] ch;
    logic       eol;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] ch
  logic       in_tlast = 1'b0;    // end_of_line
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] token_char
  logic [7:0] out_tuser;          // [0] has_char, [1] starts, [2] ends, [5:3] kind, [7:6] error
  logic       out_tlast;          // last result of the input transfer

  json_token_lexer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus bytes not yet offered, and token results still owed by the lexer
  line_byte_t byte_q[$];
  result_t    pending_tokens[$];

  int n_bytes = 1;        // total stimulus length, known once the queue is built
  int n_directed = 0;
  int bytes_sent = 0;
  int random_items = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int phase;
  int send_idle_pct;
  int recv_stall_pct;
  bit draining = 1'b0;

  // shadow lexer state
  lex_mode_t  lx_mode = MODE_IDLE;
  logic [2:0] num_state = NUM_START;
  logic [2:0] kw_live = 3'b111;
  logic [2:0] kw_seen = 3'd0;
  logic       gap_seen = 1'b0;
  logic       tok_fresh = 1'b1;

  // ---------------------------------------------------------------- character classes

  function automatic logic blank_byte(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic punct_byte(input logic [7:0] c);
    return c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK ||
           c == CH_COMMA || c == CH_COLON;
  endfunction

  function automatic logic escape_ok(input logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B ||
           c == CH_F || c == CH_N || c == CH_R || c == CH_T;
  endfunction

  // signed decimal recognizer: sign, digits, optional dot and fraction, or dot digits
  function automatic logic [2:0] number_step(input logic [2:0] s, input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      case (s)
        NUM_START, NUM_SIGN, NUM_INT: return NUM_INT;
        NUM_INT_DOT, NUM_INT_FRAC:    return NUM_INT_FRAC;
        NUM_DOT, NUM_DOT_FRAC:        return NUM_DOT_FRAC;
        default:                      return NUM_DEAD;
      endcase
    end
    if (c == CH_PLUS || c == CH_MINUS) return (s == NUM_START) ? NUM_SIGN : NUM_DEAD;
    if (c == CH_DOT) begin
      if (s == NUM_START || s == NUM_SIGN) return NUM_DOT;
      if (s == NUM_INT) return NUM_INT_DOT;
    end
    return NUM_DEAD;
  endfunction

  function automatic logic number_done(input logic [2:0] s);
    return s == NUM_INT || s == NUM_INT_DOT || s == NUM_INT_FRAC || s == NUM_DOT_FRAC;
  endfunction

  function automatic int keyword_len(input int k);
    return (k == KW_FALSE) ? 5 : 4;
  endfunction

  function automatic logic [7:0] keyword_byte(input int k, input int pos);
    string word;
    word = (k == KW_NULL) ? "null" : (k == KW_FALSE) ? "false" : "true";
    return (pos < word.len()) ? word[pos] : 8'h00;
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic result_t make_res(input logic [7:0] c, input logic has,
                                       input logic st, input logic en,
                                       input logic [2:0] kind, input logic [1:0] err);
    result_t r;
    r.token_char   = has ? c : 8'h00;
    r.has_char     = has;
    r.starts_token = st;
    r.ends_token   = en;
    r.kind         = kind;
    r.error        = err;
    r.last         = 1'b0;
    return r;
  endfunction

  task automatic reset_token(input lex_mode_t m);
    lx_mode   = m;
    num_state = NUM_START;
    kw_live   = 3'b111;
    kw_seen   = 3'd0;
    gap_seen  = 1'b0;
    tok_fresh = 1'b1;
  endtask

  task automatic feed_bare(input logic [7:0] c);
    // a space between bare bytes kills every candidate
    if (gap_seen) begin
      num_state = NUM_DEAD;
      kw_live   = 3'b000;
      gap_seen  = 1'b0;
    end
    num_state = number_step(num_state, c);
    for (int k = 0; k < 3; k++) begin
      if (kw_live[k] && (kw_seen >= keyword_len(k) || keyword_byte(k, kw_seen) != c))
        kw_live[k] = 1'b0;
    end
    if (kw_seen != 3'd7) kw_seen = kw_seen + 3'd1;
    tok_fresh = 1'b0;
  endtask

  // advance the shadow lexer by one accepted byte and queue what it owes
  task automatic lex_step(input logic [7:0] c, input logic eol);
    result_t    r[2];
    int         n;
    logic [2:0] kind;
    logic       known;
    n = 0;
    case (lx_mode)
      MODE_TEXT, MODE_ESC: begin
        if (eol) begin
          r[n] = make_res(8'h00, 1'b0, 1'b0, 1'b1, KIND_SYMBOL,
                          (lx_mode == MODE_ESC) ? ERR_ESCAPE : ERR_UNTERM);
          n++;
          reset_token(MODE_IDLE);
        end else if (lx_mode == MODE_ESC) begin
          if (escape_ok(c)) begin
            r[n] = make_res(c, 1'b1, 1'b0, 1'b0, KIND_SYMBOL, ERR_NONE);
            n++;
            lx_mode = MODE_TEXT;
          end else begin
            // offending byte is swallowed, rest of the line skipped
            r[n] = make_res(8'h00, 1'b0, 1'b0, 1'b1, KIND_SYMBOL, ERR_ESCAPE);
            n++;
            reset_token(MODE_SKIP);
          end
        end else if (c == CH_QUOTE) begin
          r[n] = make_res(c, 1'b1, 1'b0, 1'b1, KIND_TEXT, ERR_NONE);
          n++;
          reset_token(MODE_IDLE);
        end else begin
          r[n] = make_res(c, 1'b1, 1'b0, 1'b0, KIND_SYMBOL, ERR_NONE);
          n++;
          if (c == CH_BSLASH) lx_mode = MODE_ESC;
        end
      end
      MODE_BARE: begin
        if (eol || punct_byte(c)) begin
          known = 1'b1;
          if (kw_live[KW_NULL] && kw_seen == 3'd4) kind = KIND_NULL;
          else if ((kw_live[KW_FALSE] && kw_seen == 3'd5) ||
                   (kw_live[KW_TRUE] && kw_seen == 3'd4)) kind = KIND_BOOL;
          else if (number_done(num_state)) kind = KIND_NUMBER;
          else begin
            kind  = KIND_SYMBOL;
            known = 1'b0;
          end
          if (!known) begin
            // closing symbol is dropped along with the rest of the line
            r[n] = make_res(8'h00, 1'b0, 1'b0, 1'b1, KIND_SYMBOL, ERR_BARE);
            n++;
            reset_token(eol ? MODE_IDLE : MODE_SKIP);
          end else begin
            r[n] = make_res(8'h00, 1'b0, 1'b0, 1'b1, kind, ERR_NONE);
            n++;
            if (!eol) begin
              r[n] = make_res(c, 1'b1, 1'b1, 1'b1, KIND_SYMBOL, ERR_NONE);
              n++;
            end
            reset_token(MODE_IDLE);
          end
        end else if (blank_byte(c)) begin
          gap_seen = 1'b1;
        end else begin
          feed_bare(c);
          r[n] = make_res(c, 1'b1, 1'b0, 1'b0, KIND_SYMBOL, ERR_NONE);
          n++;
        end
      end
      MODE_SKIP: begin
        if (eol) reset_token(MODE_IDLE);
      end
      default: begin
        // idle, unused codes behave the same
        if (eol) begin
          reset_token(MODE_IDLE);
        end else if (blank_byte(c)) begin
        end else if (punct_byte(c)) begin
          r[n] = make_res(c, 1'b1, 1'b1, 1'b1, KIND_SYMBOL, ERR_NONE);
          n++;
        end else if (c == CH_QUOTE) begin
          reset_token(MODE_TEXT);
          tok_fresh = 1'b0;
          r[n] = make_res(c, 1'b1, 1'b1, 1'b0, KIND_SYMBOL, ERR_NONE);
          n++;
        end else begin
          reset_token(MODE_BARE);
          feed_bare(c);
          r[n] = make_res(c, 1'b1, 1'b1, 1'b0, KIND_SYMBOL, ERR_NONE);
          n++;
        end
      end
    endcase
    if (n > 0) r[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_tokens.insert(pending_tokens.size(), r[i]);
  endtask

  // ---------------------------------------------------------------- stimulus builders

  task automatic push_byte(input logic [7:0] c);
    line_byte_t b;
    b.ch  = c;
    b.eol = 1'b0;
    byte_q.insert(byte_q.size(), b);
    random_items++;
  endtask

  task automatic push_eol();
    line_byte_t b;
    b.ch  = 8'($urandom_range(255));  // ignored by the lexer, still toggled
    b.eol = 1'b1;
    byte_q.insert(byte_q.size(), b);
    random_items++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(5))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_COMMA;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(7))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return CH_B;
      4:       return CH_F;
      5:       return CH_N;
      6:       return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(1)) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(4));  // tab through carriage return
  endfunction

  task automatic gen_text();
    int         len;
    int         p;
    logic [7:0] c;
    push_byte(CH_QUOTE);
    len = $urandom_range(6);
    for (int i = 0; i < len; i++) begin
      p = $urandom_range(99);
      if (p < 12) begin
        push_byte(CH_BSLASH);
        push_byte(pick_escape());
      end else if (p < 16) begin
        push_byte(CH_BSLASH);
        push_byte(8'($urandom_range(255)));
      end else begin
        c = 8'($urandom_range(255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_A;
        push_byte(c);
      end
    end
    // a few stay open until the line end
    if ($urandom_range(99) < 92) push_byte(CH_QUOTE);
  endtask

  task automatic gen_digits();
    int len;
    len = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) push_byte(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic gen_number();
    int form;
    if ($urandom_range(3) == 0) push_byte($urandom_range(1) ? CH_MINUS : CH_PLUS);
    form = $urandom_range(2);
    if (form != 2) gen_digits();
    if (form != 0) push_byte(CH_DOT);
    if (form == 2 || (form == 1 && $urandom_range(1))) gen_digits();
    // occasional malformed tail
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       push_byte(CH_DOT);
        1:       push_byte(CH_PLUS);
        2:       push_byte(CH_MINUS);
        default: push_byte(CH_E);
      endcase
    end
  endtask

  task automatic gen_keyword();
    int         k;
    int         cut;
    logic [7:0] c;
    k   = $urandom_range(2);
    cut = keyword_len(k);
    if ($urandom_range(7) == 0) cut = $urandom_range(1, cut - 1);
    for (int pos = 0; pos < cut; pos++) begin
      if (pos == 2 && $urandom_range(19) == 0) push_byte(CH_SPACE);
      c = keyword_byte(k, pos);
      if ($urandom_range(19) == 0) c = CH_A + 8'($urandom_range(25));
      push_byte(c);
    end
    if ($urandom_range(9) == 0) push_byte(CH_E);
  endtask

  // optional trailing spaces, then usually a symbol to close the bare token
  task automatic close_bare();
    if ($urandom_range(99) < 25) begin
      push_byte(CH_SPACE);
      if ($urandom_range(1)) push_byte(CH_SPACE);
    end
    if ($urandom_range(99) < 70) push_byte(pick_symbol());
  endtask

  task automatic gen_line();
    int ntok;
    int p;
    ntok = $urandom_range(8);
    for (int i = 0; i < ntok; i++) begin
      p = $urandom_range(99);
      if (p < 25) push_byte(pick_symbol());
      else if (p < 45) gen_text();
      else if (p < 62) begin
        gen_keyword();
        close_bare();
      end else if (p < 80) begin
        gen_number();
        close_bare();
      end else begin
        push_byte(8'($urandom_range(255)));
        close_bare();
      end
      if ($urandom_range(2) == 0) push_byte(pick_blank());
    end
    push_eol();
  endtask

  // ---------------------------------------------------------------- idling by phase

  always_comb begin
    phase = (bytes_sent * 4) / n_bytes;
    send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 37 : 0;
    recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 37 : 0;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_step(in_tdata, in_tlast);
        bytes_sent++;
        // hold off until the lexer has caught up: after the directed part and at
        // each phase change
        if (bytes_sent == n_directed || (bytes_sent * 4) % n_bytes < 4)
          draining = 1'b1;
      end
      if (draining && pending_tokens.size() == 0) draining = 1'b0;
      if (in_tvalid && !in_tready) begin
        // transfer still offered, hold it
      end else if (!draining && byte_q.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= byte_q[0].ch;
        in_tlast  <= byte_q[0].eol;
        void'(byte_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected result, expected none actual char %0h marks %0h last %0b",
                   $time, out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_char", want.token_char, out_tdata);
          check_field("has_char", want.has_char, out_tuser[0]);
          check_field("starts_token", want.starts_token, out_tuser[1]);
          check_field("ends_token", want.ends_token, out_tuser[2]);
          check_field("kind", want.kind, out_tuser[5:3]);
          check_field("error", want.error, out_tuser[7:6]);
          check_field("last", want.last, out_tlast);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("** json_token_lexer_top: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // directed lines
    push_eol();                          // line end while idle
    push_str("[true ,");                 // symbol, boolean with trailing space, closed by symbol
    push_str("\"\\/\"");                 // text with an accepted escape
    push_str("n u");                     // inner space makes the bare token invalid
    push_eol();                          // line end closes the bare token
    push_byte(8'hFF);                    // high byte as a bare token, unrecognized
    push_byte(CH_COLON);                 // dropped, then skipping
    push_eol();                          // line end while skipping
    push_str("\"\\");
    push_eol();                          // line end right after a backslash
    push_byte(CH_QUOTE);
    push_byte(8'h00);
    push_eol();                          // unterminated text
    push_str("\"\\q");                   // bad escape
    push_eol();
    n_directed = byte_q.size();

    // random lines
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(19) == 0) push_eol();
      else gen_line();
    end
    n_bytes = byte_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent < n_bytes) @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** json_token_lexer_top: PASSED **");
    end else begin
      $display("** json_token_lexer_top: FAILED **");
    end
    $finish;
  end

endmodule
